### src/sgbs_pkg.sv
// ----------------------------------------------------------------------------
// sgbs_pkg: shared constants and types for the background subtractor
// Widths, register indexes, reset values and the per-channel model entry.
// ----------------------------------------------------------------------------
package sgbs_pkg;

    localparam int PIXELS_DEFAULT = 524288;
    localparam int IDX_W          = 19;
    localparam int MEAN_W         = 16;
    localparam int VAR_W          = 24;
    localparam int FACTOR_W       = 15;
    localparam int ALPHA_W        = 17;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 17;

    localparam logic [CFG_ADDR_W-1:0] REG_FACTOR = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA  = 1'b1;

    localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 15'd25600;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 15'd1600;
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = 17'd65536;
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 17'd62259;
    localparam logic [VAR_W-1:0]    SEED_VAR     = 24'd4096;

    localparam logic CMD_DETECT = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // One colour channel of the model
    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]  var_q;
    } chan_model_t;

    // Item context carried along the pipeline
    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic             in_range;
        logic             mask;
        logic             seed;
        logic [7:0]       b;
        logic [7:0]       g;
        logic [7:0]       r;
    } item_t;

endpackage

### src/sgbs_chan.sv
// ----------------------------------------------------------------------------
// sgbs_chan: per-channel detect and update arithmetic
// Three register stages: products, blend terms, final sums and saturation.
// Advances on en; valid bits are kept by the caller.
// ----------------------------------------------------------------------------
module sgbs_chan
    import sgbs_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [7:0]          sample,
    input  chan_model_t         model_in,
    input  logic [FACTOR_W-1:0] factor,
    input  logic [ALPHA_W-1:0]  alpha,
    output logic                exceeds,
    output chan_model_t         model_out
);

    // Stage 1: detect products, new mean
    logic [15:0] s_w;
    logic [15:0] d_w;
    logic [16:0] beta_w;
    logic [33:0] nm_sum_w;
    logic [17:0] nm_raw_w;
    logic [15:0] nm_w;

    logic [31:0] dd_reg;
    logic [38:0] vf_reg;
    logic [15:0] nm_reg;
    logic [15:0] old_reg;
    logic [15:0] s1_reg;
    logic [VAR_W-1:0] var1_reg;
    logic [16:0] a1_reg;

    assign s_w      = {sample, 8'd0};
    assign d_w      = (model_in.mean >= s_w) ? model_in.mean - s_w : s_w - model_in.mean;
    assign beta_w   = 17'(ALPHA_ONE - alpha);
    assign nm_sum_w = 34'(alpha * model_in.mean) + 34'(beta_w * s_w) + 34'd32768;
    assign nm_raw_w = nm_sum_w[33:16];
    assign nm_w     = (nm_raw_w > 18'hFFFF) ? 16'hFFFF : nm_raw_w[15:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            dd_reg   <= d_w * d_w;
            vf_reg   <= model_in.var_q * factor;
            nm_reg   <= nm_w;
            old_reg  <= model_in.mean;
            s1_reg   <= s_w;
            var1_reg <= model_in.var_q;
            a1_reg   <= alpha;
        end
    end

    // Stage 2: squared deviations of the new mean
    logic [15:0] m_w;
    logic [15:0] e_w;
    logic        ex2_reg;
    logic [32:0] vm_reg;
    logic [31:0] ee_reg;
    logic [15:0] nm2_reg;
    logic [16:0] a2_reg;

    assign m_w = (nm_reg >= old_reg) ? nm_reg - old_reg : old_reg - nm_reg;
    assign e_w = (nm_reg >= s1_reg) ? nm_reg - s1_reg : s1_reg - nm_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ex2_reg <= {7'd0, dd_reg} > vf_reg;
            vm_reg  <= {1'b0, var1_reg, 8'd0} + {1'b0, 32'(m_w * m_w)};
            ee_reg  <= e_w * e_w;
            nm2_reg <= nm_reg;
            a2_reg  <= a1_reg;
        end
    end

    // Stage 3: blend the variance, round and saturate
    logic [16:0] b2_w;
    logic [50:0] nv_sum_w;
    logic [26:0] nv_raw_w;

    assign b2_w     = 17'(ALPHA_ONE - a2_reg);
    assign nv_sum_w = 51'(a2_reg * vm_reg) + 51'(b2_w * ee_reg) + 51'd8388608;
    assign nv_raw_w = nv_sum_w[50:24];

    always_ff @(posedge aclk) begin
        if (en) begin
            exceeds         <= ex2_reg;
            model_out.mean  <= nm2_reg;
            model_out.var_q <= (nv_raw_w > 27'hFFFFFF) ? 24'hFFFFFF : nv_raw_w[23:0];
        end
    end

endmodule

### src/single_gaussian_background_subtract.sv
// ----------------------------------------------------------------------------
// single_gaussian_background_subtract: running-Gaussian background subtractor
// Per-pixel BGR mean/variance model with detect and masked update commands.
// ----------------------------------------------------------------------------
// One pixel is accepted every clock while the result side keeps up and the
// read stage is not held. Each transaction goes through a six-stage
// pipeline: model memory read (two stages), three arithmetic stages and a
// write-back/output stage. The model lives in one memory word per pixel
// holding all three channels. A transaction whose pixel still has a model
// write pending further down the pipe waits at the read stage, with the
// input held off, until that write lands; writes already made since the
// memory read are forwarded to it from a short write history. Detect
// commands produce one result each; update commands produce none.
module single_gaussian_background_subtract
    import sgbs_pkg::*;
#(
    parameter int PIXELS = PIXELS_DEFAULT
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command, pixel_index, blue, green, red, foreground_in (pad to 48 bits)
    input  logic [47:0]           s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_index, foreground (pad to 24 bits)
    output logic [23:0]           m_tdata
);

    localparam int AW = (PIXELS <= 2) ? 1 :
                        (($clog2(PIXELS) > IDX_W) ? IDX_W : $clog2(PIXELS));
    localparam int NST = 6;
    typedef logic [3*(MEAN_W+VAR_W)-1:0] word_t;

    // Configuration registers, saturated on write
    logic [FACTOR_W-1:0] factor_reg;
    logic [ALPHA_W-1:0]  alpha_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_RESET;
            alpha_reg  <= ALPHA_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == REG_FACTOR)
                factor_reg <= (cfg_wdata[FACTOR_W-1:0] > FACTOR_MAX) ? FACTOR_MAX
                                                                   : cfg_wdata[FACTOR_W-1:0];
            else if (cfg_addr == REG_ALPHA)
                alpha_reg <= (cfg_wdata > ALPHA_ONE) ? ALPHA_ONE : cfg_wdata;
        end
    end

    // Pipeline advance: whole pipe stalls when the output holds a result
    logic en;
    logic hazard;
    logic [4:1] wpend_w;
    logic [NST-1:0] v_reg;
    item_t          it_reg [NST];
    logic           ready_reg;
    item_t          in_w;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && !hazard;

    assign in_w.cmd      = s_tdata[0];
    assign in_w.idx      = s_tdata[19:1];
    assign in_w.b        = s_tdata[27:20];
    assign in_w.g        = s_tdata[35:28];
    assign in_w.r        = s_tdata[43:36];
    assign in_w.mask     = s_tdata[44];
    assign in_w.in_range = ({13'd0, s_tdata[19:1]} < 32'(PIXELS));
    assign in_w.seed     = !ready_reg;

    // Hold the read stage while an older transaction will still write its pixel
    always_comb begin
        for (int j = 1; j <= 4; j++)
            wpend_w[j] = v_reg[j] && it_reg[j].in_range &&
                         (it_reg[j].seed ||
                          (it_reg[j].cmd == CMD_UPDATE && !it_reg[j].mask)) &&
                         (it_reg[j].idx[AW-1:0] == it_reg[0].idx[AW-1:0]);
        hazard = v_reg[0] && it_reg[0].in_range && !it_reg[0].seed && (|wpend_w);
    end

    // Seeding ends after the first end-of-frame pixel
    always_ff @(posedge aclk) begin
        if (!aresetn)
            ready_reg <= 1'b0;
        else if (s_tvalid && s_tready && s_tlast)
            ready_reg <= 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v_reg <= '0;
        else if (en) begin
            if (!hazard)
                v_reg[0] <= s_tvalid;
            v_reg[1]       <= v_reg[0] && !hazard;
            v_reg[NST-1:2] <= v_reg[NST-2:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!hazard)
                it_reg[0] <= in_w;
            for (int i = 1; i < NST; i++)
                it_reg[i] <= it_reg[i-1];
        end
    end

    // Model memory, read as an item enters stage 0 with registered data in stage 0
    word_t mem [PIXELS];
    word_t rd_reg;
    word_t wr_data;
    logic  wr_en;
    logic [AW-1:0] wr_addr;

    always_ff @(posedge aclk) begin
        if (en && !hazard)
            rd_reg <= mem[in_w.idx[AW-1:0]];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Write-back stage (stage 4) results, and a history of recent writes
    logic [NST-1:0]  hv_reg;
    logic [AW-1:0]   ha_reg [NST];
    word_t           hd_reg [NST];

    // Forward newest write made since the memory read for the pixel at stage 0
    word_t fwd_w;
    always_comb begin
        fwd_w = rd_reg;
        for (int k = NST-1; k >= 0; k--)
            if (hv_reg[k] && ha_reg[k] == it_reg[0].idx[AW-1:0])
                fwd_w = hd_reg[k];
    end

    // Stage 1: pick the model (memory, forward or seed)
    chan_model_t mb_reg, mg_reg, mr_reg;
    chan_model_t mb_w, mg_w, mr_w;
    always_comb begin
        {mb_w, mg_w, mr_w} = fwd_w;
        if (it_reg[0].seed) begin
            mb_w = '{mean: {it_reg[0].b, 8'd0}, var_q: SEED_VAR};
            mg_w = '{mean: {it_reg[0].g, 8'd0}, var_q: SEED_VAR};
            mr_w = '{mean: {it_reg[0].r, 8'd0}, var_q: SEED_VAR};
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            mb_reg <= mb_w;
            mg_reg <= mg_w;
            mr_reg <= mr_w;
        end
    end

    // Arithmetic stages 2..4
    logic        exb, exg, exr;
    chan_model_t nb, ng, nr;
    sgbs_chan u_b (.aclk, .en, .sample(it_reg[1].b), .model_in(mb_reg),
                   .factor(factor_reg), .alpha(alpha_reg), .exceeds(exb), .model_out(nb));
    sgbs_chan u_g (.aclk, .en, .sample(it_reg[1].g), .model_in(mg_reg),
                   .factor(factor_reg), .alpha(alpha_reg), .exceeds(exg), .model_out(ng));
    sgbs_chan u_r (.aclk, .en, .sample(it_reg[1].r), .model_in(mr_reg),
                   .factor(factor_reg), .alpha(alpha_reg), .exceeds(exr), .model_out(nr));

    // Seed value carried to write-back for masked updates and detects
    chan_model_t sb_reg [3], sg_reg [3], sr_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= mb_reg; sg_reg[0] <= mg_reg; sr_reg[0] <= mr_reg;
            for (int i = 1; i < 3; i++) begin
                sb_reg[i] <= sb_reg[i-1];
                sg_reg[i] <= sg_reg[i-1];
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    // Stage 4 item: decide the write
    item_t wi;
    logic  do_upd, do_wr;
    assign wi     = it_reg[4];
    assign do_upd = wi.cmd == CMD_UPDATE && !wi.mask;
    assign do_wr  = v_reg[4] && en && wi.in_range && (wi.seed || do_upd);
    assign wr_en   = do_wr;
    assign wr_addr = wi.idx[AW-1:0];
    assign wr_data = do_upd ? {nb, ng, nr} : {sb_reg[2], sg_reg[2], sr_reg[2]};

    always_ff @(posedge aclk) begin
        if (!aresetn)
            hv_reg <= '0;
        else if (en)
            hv_reg <= {hv_reg[NST-2:0], do_wr};
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            ha_reg[0] <= wr_addr;
            hd_reg[0] <= wr_data;
            for (int i = 1; i < NST; i++) begin
                ha_reg[i] <= ha_reg[i-1];
                hd_reg[i] <= hd_reg[i-1];
            end
        end
    end

    // Output register
    logic [IDX_W-1:0] oi_reg;
    logic             of_reg;
    logic             ov_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= v_reg[4] && wi.cmd == CMD_DETECT;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            oi_reg <= wi.idx;
            of_reg <= wi.in_range && (exb || exg || exr);
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, of_reg, oi_reg};

    // A stalled pipe writes nothing
    assert property (@(posedge aclk) disable iff (!aresetn) !en |-> !wr_en)
        else $error("model write during stall");
    // Only detect commands produce results
    assert property (@(posedge aclk) disable iff (!aresetn)
        en && v_reg[4] && wi.cmd == CMD_UPDATE |=> !m_tvalid)
        else $error("result from update command");
    // Model-ready flag never clears once set, so seeding never restarts
    assert property (@(posedge aclk) disable iff (!aresetn) ready_reg |=> ready_reg)
        else $error("model ready dropped");

endmodule
